// ===== sv/vad_pkg.sv =====
// ----------------------------------------------------------------------------
// vad_pkg
// Types, constants and the arctangent table shared by the vector angle blocks.
// ----------------------------------------------------------------------------
package vad_pkg;

    localparam int COMPONENT_WIDTH = 16;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int CORDIC_STEPS    = 16;
    localparam int ANGLE_WIDTH     = 17;
    localparam int INT_FRAC        = 22;
    localparam int PRESCALE        = 24;
    localparam int TABLE_LEN       = 24;
    localparam int XW              = COMPONENT_WIDTH + PRESCALE + 3;
    localparam int ZW              = 32;

    localparam logic signed [ZW-1:0] DEG_90  = ZW'(90)  <<< INT_FRAC;
    localparam logic signed [ZW-1:0] DEG_180 = ZW'(180) <<< INT_FRAC;
    localparam logic signed [ZW-1:0] DEG_270 = ZW'(270) <<< INT_FRAC;
    localparam logic signed [ZW-1:0] DEG_360 = ZW'(360) <<< INT_FRAC;

    typedef struct packed {
        logic signed [COMPONENT_WIDTH-1:0] vec_x;
        logic signed [COMPONENT_WIDTH-1:0] vec_y;
    } vec_beat_t;

    typedef struct packed {
        logic [ANGLE_WIDTH-1:0] angle_deg;
        logic                   zero_vector;
    } angle_beat_t;

    typedef struct packed {
        logic signed [XW-1:0] x;
        logic signed [XW-1:0] y;
        logic signed [ZW-1:0] z;
        logic                 skip;
        logic                 zero;
    } cordic_t;

    // Arctangent of 2^-idx in degrees, in units of 2^-22 degree.
    function automatic logic signed [ZW-1:0] atan_entry(input int idx);
        logic signed [ZW-1:0] val;
        case (idx)
            0:       val = 32'sd188743680;
            1:       val = 32'sd111421900;
            2:       val = 32'sd58872272;
            3:       val = 32'sd29884485;
            4:       val = 32'sd15000234;
            5:       val = 32'sd7507429;
            6:       val = 32'sd3754631;
            7:       val = 32'sd1877430;
            8:       val = 32'sd938729;
            9:       val = 32'sd469366;
            10:      val = 32'sd234683;
            11:      val = 32'sd117342;
            12:      val = 32'sd58671;
            13:      val = 32'sd29335;
            14:      val = 32'sd14668;
            15:      val = 32'sd7334;
            16:      val = 32'sd3667;
            17:      val = 32'sd1833;
            18:      val = 32'sd917;
            19:      val = 32'sd458;
            20:      val = 32'sd229;
            21:      val = 32'sd115;
            22:      val = 32'sd57;
            23:      val = 32'sd29;
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== sv/vad_prep.sv =====
// ----------------------------------------------------------------------------
// vad_prep
// Input stage: folds the vector into the right half plane and sets up the
// starting angle and the special cases.
// ----------------------------------------------------------------------------
module vad_prep (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               vec_valid,
    input  vad_pkg::vec_beat_t vec_beat,
    output logic               out_valid,
    output vad_pkg::cordic_t   out_beat
);
    import vad_pkg::*;

    logic    valid_reg;
    cordic_t beat_reg;
    cordic_t beat_next;

    logic signed [XW-1:0] xe;
    logic signed [XW-1:0] ye;

    always_comb
    begin
        xe = XW'(vec_beat.vec_x);
        ye = -XW'(vec_beat.vec_y);
        beat_next.zero = 1'b0;
        beat_next.skip = 1'b0;
        beat_next.z    = '0;
        beat_next.x    = xe;
        beat_next.y    = ye;
        if (xe == '0 && ye == '0)
        begin
            beat_next.zero = 1'b1;
            beat_next.skip = 1'b1;
        end
        else if (xe == '0)
        begin
            beat_next.skip = 1'b1;
            beat_next.z    = (ye > 0) ? DEG_90 : DEG_270;
        end
        else
        begin
            if (xe < 0)
            begin
                beat_next.x = -xe;
                beat_next.y = -ye;
                beat_next.z = DEG_180;
            end
            beat_next.skip = (ye == '0);
        end
        beat_next.x = beat_next.x <<< PRESCALE;
        beat_next.y = beat_next.y <<< PRESCALE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= vec_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== sv/vad_stage.sv =====
// ----------------------------------------------------------------------------
// vad_stage
// One vectoring rotation step, registered.
// ----------------------------------------------------------------------------
module vad_stage #(
    parameter int STEP = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             en,
    input  logic             in_valid,
    input  vad_pkg::cordic_t in_beat,
    output logic             out_valid,
    output vad_pkg::cordic_t out_beat
);
    import vad_pkg::*;

    localparam logic signed [ZW-1:0] ATAN = atan_entry(STEP);

    logic    valid_reg;
    cordic_t beat_reg;
    cordic_t beat_next;

    logic signed [XW-1:0] xs;
    logic signed [XW-1:0] ys;

    always_comb
    begin
        xs        = in_beat.x >>> STEP;
        ys        = in_beat.y >>> STEP;
        beat_next = in_beat;
        if (!in_beat.skip)
        begin
            if (in_beat.y > 0)
            begin
                beat_next.x = in_beat.x + ys;
                beat_next.y = in_beat.y - xs;
                beat_next.z = in_beat.z + ATAN;
            end
            else
            begin
                beat_next.x = in_beat.x - ys;
                beat_next.y = in_beat.y + xs;
                beat_next.z = in_beat.z - ATAN;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            beat_reg <= beat_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_beat  = beat_reg;

endmodule

// ===== sv/vad_final.sv =====
// ----------------------------------------------------------------------------
// vad_final
// Wraps the accumulated angle into one turn, then rounds it to the output
// fraction and holds the result beat.
// ----------------------------------------------------------------------------
module vad_final #(
    parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  vad_pkg::cordic_t     in_beat,
    output logic                 out_valid,
    output vad_pkg::angle_beat_t out_beat
);
    import vad_pkg::*;

    localparam int SHIFT = INT_FRAC - ANGLE_FRAC_BITS;
    localparam logic [ZW-1:0] HALF  = ZW'(1) << (SHIFT - 1);
    localparam logic [ZW-1:0] LIMIT = ZW'(360) << ANGLE_FRAC_BITS;

    logic                 wrap_valid_reg;
    logic [ZW-1:0]        wrap_angle_reg;
    logic [ZW-1:0]        wrap_angle_next;
    logic                 wrap_zero_reg;
    logic signed [ZW-1:0] t1;
    logic signed [ZW-1:0] t2;

    logic                 out_valid_reg;
    angle_beat_t          out_beat_reg;
    angle_beat_t          out_beat_next;
    logic [ZW-1:0]        rounded;

    always_comb
    begin
        t1 = (in_beat.z < 0) ? in_beat.z + DEG_360 : in_beat.z;
        t2 = (t1 >= DEG_360) ? t1 - DEG_360 : t1;
        wrap_angle_next = t2;
    end

    always_comb
    begin
        rounded = (wrap_angle_reg + HALF) >> SHIFT;
        out_beat_next.zero_vector = wrap_zero_reg;
        if (wrap_zero_reg || rounded >= LIMIT)
        begin
            out_beat_next.angle_deg = '0;
        end
        else
        begin
            out_beat_next.angle_deg = rounded[ANGLE_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wrap_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            wrap_valid_reg <= in_valid;
            out_valid_reg  <= wrap_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wrap_angle_reg <= wrap_angle_next;
            wrap_zero_reg  <= in_beat.zero;
            out_beat_reg   <= out_beat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

endmodule

// ===== sv/vector_angle_degrees.sv =====
// ----------------------------------------------------------------------------
// vector_angle_degrees
// Direction of a screen-space vector in degrees by a pipelined CORDIC.
// The stages are one input stage, one stage per CORDIC step used, one wrap
// stage and the output register. Throughput is one beat per cycle; the whole
// pipeline holds while a result beat is stalled. Reset clears only the valid
// bits of every stage.
// ----------------------------------------------------------------------------
module vector_angle_degrees #(
    parameter int ANGLE_FRAC_BITS = vad_pkg::ANGLE_FRAC_BITS,
    parameter int CORDIC_STEPS    = vad_pkg::CORDIC_STEPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 vec_valid,
    output logic                 vec_stall,
    input  vad_pkg::vec_beat_t   vec_beat,
    output logic                 angle_valid,
    input  logic                 angle_stall,
    output vad_pkg::angle_beat_t angle_beat
);
    import vad_pkg::*;

    localparam int STEPS_USED = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;

    logic    en;
    logic    stage_valid [STEPS_USED+1];
    cordic_t stage_beat  [STEPS_USED+1];

    assign en        = !(angle_valid && angle_stall);
    assign vec_stall = !en;

    vad_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .vec_valid (vec_valid),
        .vec_beat  (vec_beat),
        .out_valid (stage_valid[0]),
        .out_beat  (stage_beat[0])
    );

    for (genvar i = 0; i < STEPS_USED; i++)
    begin : g_step
        vad_stage #(
            .STEP (i)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stage_valid[i]),
            .in_beat   (stage_beat[i]),
            .out_valid (stage_valid[i+1]),
            .out_beat  (stage_beat[i+1])
        );
    end

    vad_final #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_final (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stage_valid[STEPS_USED]),
        .in_beat   (stage_beat[STEPS_USED]),
        .out_valid (angle_valid),
        .out_beat  (angle_beat)
    );

endmodule

// ===== dv/vector_angle_degrees_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector_angle_degrees_tb
// Self-checking testbench for the screen-space vector angle block. Directed
// vectors cover the zero vector, the axes, the quadrant borders and the
// component extremes. Random vectors then mix full-range, small, axis-aligned
// and near-axis cases. Each beat is predicted by a 64-bit CORDIC model and
// compared with the result beats in order, under random idling on both sides
// and one long stretch without it.
// ----------------------------------------------------------------------------
module vector_angle_degrees_tb;

    import vad_pkg::*;

    localparam int HALF_PERIOD    = 6;
    localparam int RESET_CYCLES   = 6;
    localparam int PIPE_LATENCY   = CORDIC_STEPS + 3;
    localparam int CYCLE_LIMIT    = 200000;
    localparam int IDLE_PCT       = 18;
    localparam int MIXED_VECTORS  = 800;
    localparam int STEADY_VECTORS = 200;
    localparam int OUT_SHIFT      = INT_FRAC - ANGLE_FRAC_BITS;

    localparam longint FULL_TURN = longint'(360) <<< INT_FRAC;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        vec_valid   = 1'b0;
    logic        vec_stall;
    vec_beat_t   vec_beat    = '0;
    logic        angle_valid;
    logic        angle_stall = 1'b0;
    angle_beat_t angle_beat;

    bit          idling_on       = 1'b1;
    int          error_count     = 0;
    int          vectors_sent    = 0;
    int          directed_sent   = 0;
    int          angles_checked  = 0;
    int          zeros_seen      = 0;
    int          cycle_count     = 0;
    angle_beat_t expected_angles[$];

    longint atan_units [0:TABLE_LEN-1] = '{
        188743680, 111421900, 58872272, 29884485, 15000234, 7507429,
        3754631, 1877430, 938729, 469366, 234683, 117342,
        58671, 29335, 14668, 7334, 3667, 1833,
        917, 458, 229, 115, 57, 29
    };

    vector_angle_degrees u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .vec_valid   (vec_valid),
        .vec_stall   (vec_stall),
        .vec_beat    (vec_beat),
        .angle_valid (angle_valid),
        .angle_stall (angle_stall),
        .angle_beat  (angle_beat)
    );

    always
    begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    function automatic angle_beat_t predict_heading(input vec_beat_t v);
        angle_beat_t         r;
        longint              cx;
        longint              cy;
        longint              dx;
        longint              dy;
        longint              turn;
        longint              acc;
        longint              total;
        longint unsigned     scaled;
        int                  steps;
        r     = '0;
        cx    = longint'(v.vec_x);
        cy    = -longint'(v.vec_y);
        turn  = 0;
        acc   = 0;
        steps = (CORDIC_STEPS > TABLE_LEN) ? TABLE_LEN : CORDIC_STEPS;
        if (cx == 0 && cy == 0)
        begin
            r.zero_vector = 1'b1;
            return r;
        end
        if (cx == 0)
        begin
            acc = longint'((cy > 0) ? 90 : 270) <<< INT_FRAC;
        end
        else
        begin
            if (cx < 0)
            begin
                cx   = -cx;
                cy   = -cy;
                turn = longint'(180) <<< INT_FRAC;
            end
            if (cy != 0)
            begin
                cx = cx <<< PRESCALE;
                cy = cy <<< PRESCALE;
                for (int i = 0; i < steps; i++)
                begin
                    dx = cx >>> i;
                    dy = cy >>> i;
                    if (cy > 0)
                    begin
                        cx  = cx + dy;
                        cy  = cy - dx;
                        acc = acc + atan_units[i];
                    end
                    else
                    begin
                        cx  = cx - dy;
                        cy  = cy + dx;
                        acc = acc - atan_units[i];
                    end
                end
            end
        end
        total = turn + acc;
        if (total < 0)
            total = total + FULL_TURN;
        if (total >= FULL_TURN)
            total = total - FULL_TURN;
        scaled = ($unsigned(total) + (64'd1 << (OUT_SHIFT - 1))) >> OUT_SHIFT;
        if (scaled >= (64'd360 << ANGLE_FRAC_BITS))
            scaled = 0;
        r.angle_deg = scaled[ANGLE_WIDTH-1:0];
        return r;
    endfunction

    function automatic vec_beat_t make_vector(input int x, input int y);
        vec_beat_t b;
        b.vec_x = COMPONENT_WIDTH'(x);
        b.vec_y = COMPONENT_WIDTH'(y);
        return b;
    endfunction

    function automatic int random_big();
        return int'($urandom_range(65535)) - 32768;
    endfunction

    function automatic int random_tiny();
        return int'($urandom_range(6)) - 3;
    endfunction

    function automatic vec_beat_t random_vector();
        vec_beat_t b;
        int        pick;
        pick = $urandom_range(9);
        case (pick)
            0, 1, 2, 3, 4:
                b = make_vector(random_big(), random_big());
            5, 6:
                b = make_vector(int'($urandom_range(16)) - 8, int'($urandom_range(16)) - 8);
            7:
                b = ($urandom_range(1) == 1) ? make_vector(0, random_big())
                                             : make_vector(random_big(), 0);
            8:
                b = ($urandom_range(1) == 1) ? make_vector(random_tiny(), random_big())
                                             : make_vector(random_big(), random_tiny());
            default:
                b = make_vector(($urandom_range(1) == 1) ? 32767 : -32768,
                                int'($urandom_range(2)) * 32767 - 32768
                                + int'($urandom_range(1)));
        endcase
        return b;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("ERROR %0t ns: %s", $time, msg);
        error_count++;
    endtask

    task automatic send_vector(input vec_beat_t b);
        while (idling_on && $urandom_range(99) < IDLE_PCT)
        begin
            vec_valid <= 1'b0;
            @(negedge clk);
        end
        vec_valid <= 1'b1;
        vec_beat  <= b;
        @(posedge clk);
        while (vec_stall)
            @(posedge clk);
        expected_angles.push_back(predict_heading(b));
        vectors_sent++;
        @(negedge clk);
    endtask

    task automatic test_axes_and_zero();
        send_vector(make_vector(0, 0));
        send_vector(make_vector(0, 1));
        send_vector(make_vector(0, -1));
        send_vector(make_vector(1, 0));
        send_vector(make_vector(-1, 0));
        send_vector(make_vector(0, 32767));
        send_vector(make_vector(0, -32768));
        send_vector(make_vector(32767, 0));
        send_vector(make_vector(-32768, 0));
    endtask

    task automatic test_quadrant_borders();
        send_vector(make_vector(1, 1));
        send_vector(make_vector(1, -1));
        send_vector(make_vector(-1, 1));
        send_vector(make_vector(-1, -1));
        send_vector(make_vector(32767, 1));
        send_vector(make_vector(32767, -1));
        send_vector(make_vector(-32768, 1));
        send_vector(make_vector(-32768, -1));
    endtask

    task automatic test_component_extremes();
        send_vector(make_vector(32767, 32767));
        send_vector(make_vector(32767, -32768));
        send_vector(make_vector(-32768, 32767));
        send_vector(make_vector(-32768, -32768));
        send_vector(make_vector(1, -32768));
        send_vector(make_vector(-1, 32767));
        directed_sent = vectors_sent;
    endtask

    task automatic test_random_mixed(input int count);
        idling_on = 1'b1;
        repeat (count)
            send_vector(random_vector());
    endtask

    task automatic test_steady_stream(input int count);
        idling_on = 1'b0;
        repeat (count)
            send_vector(random_vector());
        idling_on = 1'b1;
    endtask

    always @(negedge clk)
    begin
        angle_stall <= idling_on && ($urandom_range(99) < IDLE_PCT);
    end

    always @(posedge clk)
    begin
        if (rst_n && angle_valid && !angle_stall)
        begin
            if (expected_angles.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result beat angle_deg=%0d zero_vector=%0b",
                                          angle_beat.angle_deg, angle_beat.zero_vector));
            end
            else
            begin
                angle_beat_t exp_beat;
                exp_beat = expected_angles.pop_front();
                angles_checked++;
                if (exp_beat.zero_vector)
                    zeros_seen++;
                if (angle_beat.angle_deg !== exp_beat.angle_deg)
                    report_mismatch($sformatf("beat %0d angle_deg got %0d expected %0d",
                                              angles_checked, angle_beat.angle_deg,
                                              exp_beat.angle_deg));
                if (angle_beat.zero_vector !== exp_beat.zero_vector)
                    report_mismatch($sformatf("beat %0d zero_vector got %0b expected %0b",
                                              angles_checked, angle_beat.zero_vector,
                                              exp_beat.zero_vector));
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped by the cycle limit with %0d results outstanding.",
                 expected_angles.size());
        $display("FAIL vector_angle_degrees");
        $finish;
    end

    initial
    begin
        repeat (RESET_CYCLES)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_axes_and_zero();
        test_quadrant_borders();
        test_component_extremes();
        test_random_mixed(MIXED_VECTORS / 2);
        test_steady_stream(STEADY_VECTORS);
        test_random_mixed(MIXED_VECTORS / 2);
        vec_valid <= 1'b0;

        while (expected_angles.size() != 0)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8)
            @(posedge clk);

        $display("Sent %0d vectors (%0d directed), checked %0d angles, %0d of them zero vectors.",
                 vectors_sent, directed_sent, angles_checked, zeros_seen);
        $display("Mismatches: %0d, cycles used: %0d.", error_count, cycle_count);
        if (error_count == 0 && expected_angles.size() == 0)
            $display("PASS vector_angle_degrees");
        else
            $display("FAIL vector_angle_degrees");
        $finish;
    end

endmodule
